/* hdl/qmn_pkg.sv */
package qmn_pkg;

  localparam int FracBits = 30;
  localparam int NormBits = 30;
  localparam int QuoW     = FracBits + 1;
  localparam int NumW     = FracBits + 32;
  localparam int SqrtSteps = 32;

  typedef struct packed {
    logic [3:0][NormBits-1:0] r;
    logic [3:0]               neg;
    logic                     zero;
  } qmn_vec_t;

  typedef struct packed {
    qmn_vec_t    vec;
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } qmn_sqrt_t;

  typedef struct packed {
    qmn_vec_t                 vec;
    logic [31:0]              n;
    logic [3:0][QuoW-1:0]     num;
    logic [3:0][31:0]         rem;
    logic [3:0][QuoW-1:0]     quo;
  } qmn_div_t;

endpackage

/* hdl/quaternion_multiply_normalized.sv */
// normalized quaternion product, fixed point with 30 fraction bits
//
// input channel s_axis: one item carries both operands a and b, components
// packed scalar first. output channel m_axis: the unit product in tdata and
// the zero-norm flag in tuser.
//
// every item passes from input to output through six stages of products,
// normalization and sum of squares, a row of 32 square root cells (one root
// bit each) and a row of 31 divider cells (one quotient bit for all four
// components each), then the output register.
// while not stalled, one item may enter every cycle; the pipeline moves as one.
//
// when the receiver stalls, the pipeline freezes and s_axis_tready_o drops
// in the same cycle, so the waiting result holds. reset empties the pipeline;
// items in flight are dropped. a zero product gives all zeros with the
// flag set.
module quaternion_multiply_normalized (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // p_w, p_x, p_y, p_z
  output logic [127:0] m_axis_tdata_o,
  // zero_norm
  output logic         m_axis_tuser_o
);
  import qmn_pkg::*;

  logic en;
  logic front_vld;
  qmn_vec_t front_vec;
  logic [63:0] front_v;

  logic      [SqrtSteps:0] sq_vld;
  qmn_sqrt_t [SqrtSteps:0] sq_dat;
  logic      [QuoW:0]      dv_vld;
  qmn_div_t  [QuoW:0]      dv_dat;

  logic         out_vld_q;
  logic [127:0] out_dat_q;
  logic         out_zero_q;
  logic [127:0] out_dat_d;
  logic [NumW-1:0] num;

  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  qmn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .opnd_i  (s_axis_tdata_i),
    .valid_o (front_vld),
    .vec_o   (front_vec),
    .v_o     (front_v)
  );

  always_comb begin
    sq_vld[0] = front_vld;
    sq_dat[0].vec  = front_vec;
    sq_dat[0].v    = front_v;
    sq_dat[0].rem  = '0;
    sq_dat[0].root = '0;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    qmn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[k]),
      .data_i  (sq_dat[k]),
      .valid_o (sq_vld[k+1]),
      .data_o  (sq_dat[k+1])
    );
  end

  // numerator r << (frac + 1) plus half the divisor root, for round to nearest
  always_comb begin
    dv_vld[0]     = sq_vld[SqrtSteps];
    dv_dat[0].vec = sq_dat[SqrtSteps].vec;
    dv_dat[0].n   = sq_dat[SqrtSteps].root;
    dv_dat[0].quo = '0;
    num = '0;
    for (int i = 0; i < 4; i++) begin
      num = (NumW'(sq_dat[SqrtSteps].vec.r[i]) << (FracBits + 1))
          + NumW'(sq_dat[SqrtSteps].root[31:1]);
      dv_dat[0].num[i] = num[QuoW-1:0];
      dv_dat[0].rem[i] = 32'(num[NumW-1:QuoW]);
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    qmn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[k]),
      .data_i  (dv_dat[k]),
      .valid_o (dv_vld[k+1]),
      .data_o  (dv_dat[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_dat[QuoW].vec.zero) begin
        out_dat_d[32*i +: 32] = '0;
      end else if (dv_dat[QuoW].vec.neg[i]) begin
        out_dat_d[32*i +: 32] = 32'(-32'(dv_dat[QuoW].quo[i]));
      end else begin
        out_dat_d[32*i +: 32] = 32'(dv_dat[QuoW].quo[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dat_q  <= out_dat_d;
      out_zero_q <= dv_dat[QuoW].vec.zero;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tuser_o  = out_zero_q;

  a_zero_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_zero_q |-> out_dat_q == '0)
    else $error("zero-norm item with nonzero components");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed(out_dat_q[31:0]) <= $signed(32'sd1 <<< FracBits)
               && $signed(out_dat_q[31:0]) >= -$signed(32'sd1 <<< FracBits)))
    else $error("scalar part out of unit range");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> out_vld_q && $stable(out_dat_q))
    else $error("stalled result changed");

endmodule

/* hdl/qmn_front.sv */
module qmn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [7:0][31:0]  opnd_i,
  output logic              valid_o,
  output qmn_pkg::qmn_vec_t vec_o,
  output logic [63:0]       v_o
);
  import qmn_pkg::*;

  logic [5:0] vld_q;

  // stage 1: sixteen products, floor divided by four
  logic signed [15:0][61:0] prod_d, prod_q;
  // stage 2: magnitudes of the four sums
  logic [3:0][63:0] mag_d, mag_q;
  logic [3:0]       neg_d, neg_q;
  // stage 3: bit length of the largest magnitude
  logic [6:0]       len_d, len_q;
  logic [3:0][63:0] mag3_q;
  logic [3:0]       neg3_q;
  // stage 4: normalized magnitudes
  logic [3:0][NormBits-1:0] r_d, r4_q, r5_q;
  logic [3:0]       neg4_q, neg5_q;
  logic             zero4_q, zero5_q;
  // stage 5: squares
  logic [3:0][59:0] sq_d, sq_q;
  // stage 6: sum of squares
  logic [61:0]      s_d;
  qmn_vec_t         vec_q;
  logic [63:0]      v_q;

  logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz;
  logic signed [63:0] c0, c1, c2, c3;
  logic [63:0]        maxm;
  logic [6:0]         sh;

  function automatic logic signed [61:0] mq(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p  = a * b;
    return p[63:2];
  endfunction

  always_comb begin
    aw = opnd_i[0]; ax = opnd_i[1]; ay = opnd_i[2]; az = opnd_i[3];
    bw = opnd_i[4]; bx = opnd_i[5]; by = opnd_i[6]; bz = opnd_i[7];
    prod_d[0]  = mq(aw, bw); prod_d[1]  = mq(ax, bx);
    prod_d[2]  = mq(ay, by); prod_d[3]  = mq(az, bz);
    prod_d[4]  = mq(ay, bz); prod_d[5]  = mq(az, by);
    prod_d[6]  = mq(aw, bx); prod_d[7]  = mq(bw, ax);
    prod_d[8]  = mq(az, bx); prod_d[9]  = mq(ax, bz);
    prod_d[10] = mq(aw, by); prod_d[11] = mq(bw, ay);
    prod_d[12] = mq(ax, by); prod_d[13] = mq(ay, bx);
    prod_d[14] = mq(aw, bz); prod_d[15] = mq(bw, az);
  end

  // an element of a packed array reads as unsigned, so extend each term as signed
  always_comb begin
    c0 = 64'($signed(prod_q[0])) - 64'($signed(prod_q[1]))
       - 64'($signed(prod_q[2])) - 64'($signed(prod_q[3]));
    c1 = 64'($signed(prod_q[4])) - 64'($signed(prod_q[5]))
       + 64'($signed(prod_q[6])) + 64'($signed(prod_q[7]));
    c2 = 64'($signed(prod_q[8])) - 64'($signed(prod_q[9]))
       + 64'($signed(prod_q[10])) + 64'($signed(prod_q[11]));
    c3 = 64'($signed(prod_q[12])) - 64'($signed(prod_q[13]))
       + 64'($signed(prod_q[14])) + 64'($signed(prod_q[15]));
    neg_d = {c3[63], c2[63], c1[63], c0[63]};
    mag_d[0] = c0[63] ? 64'(-c0) : 64'(c0);
    mag_d[1] = c1[63] ? 64'(-c1) : 64'(c1);
    mag_d[2] = c2[63] ? 64'(-c2) : 64'(c2);
    mag_d[3] = c3[63] ? 64'(-c3) : 64'(c3);
  end

  always_comb begin
    maxm = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
    len_d = '0;
    for (int i = 0; i < 64; i++) begin
      if (maxm[i]) len_d = 7'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (len_q > 7'(NormBits)) begin
        sh = len_q - 7'(NormBits);
        r_d[i] = NormBits'(mag3_q[i] >> sh);
      end else begin
        sh = 7'(NormBits) - len_q;
        r_d[i] = NormBits'(mag3_q[i] << sh);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) sq_d[i] = 60'(r4_q[i]) * 60'(r4_q[i]);
    s_d = 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]) + 62'(sq_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      len_q   <= len_d;
      mag3_q  <= mag_q;
      neg3_q  <= neg_q;
      r4_q    <= r_d;
      neg4_q  <= neg3_q;
      zero4_q <= (len_q == '0);
      sq_q    <= sq_d;
      r5_q    <= r4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
      vec_q.r    <= r5_q;
      vec_q.neg  <= neg5_q;
      vec_q.zero <= zero5_q;
      v_q     <= {s_d, 2'b00};
    end
  end

  assign valid_o = vld_q[5];
  assign vec_o   = vec_q;
  assign v_o     = v_q;

endmodule

/* hdl/qmn_sqrt_cell.sv */
module qmn_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  qmn_pkg::qmn_sqrt_t data_i,
  output logic               valid_o,
  output qmn_pkg::qmn_sqrt_t data_o
);
  import qmn_pkg::*;

  logic      valid_q;
  qmn_sqrt_t data_d, data_q;
  logic [35:0] rem_sh, trial;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    data_d = data_i;
    rem_sh = {data_i.rem, data_i.v[63:62]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d.v = {data_i.v[61:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = 34'(rem_sh - trial);
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = 34'(rem_sh);
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/qmn_div_cell.sv */
module qmn_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qmn_pkg::qmn_div_t data_i,
  output logic              valid_o,
  output qmn_pkg::qmn_div_t data_o
);
  import qmn_pkg::*;

  logic     valid_q;
  qmn_div_t data_d, data_q;
  logic [32:0] t;

  // one quotient bit for each of the four lanes
  always_comb begin
    data_d = data_i;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t = {data_i.rem[i], data_i.num[i][QuoW-1]};
      data_d.num[i] = {data_i.num[i][QuoW-2:0], 1'b0};
      if (t >= {1'b0, data_i.n}) begin
        data_d.rem[i] = 32'(t - {1'b0, data_i.n});
        data_d.quo[i] = {data_i.quo[i][QuoW-2:0], 1'b1};
      end else begin
        data_d.rem[i] = t[31:0];
        data_d.quo[i] = {data_i.quo[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
